>>> src/aesctr_pkg.sv
package aesctr_pkg;

    localparam int KeyWidth   = 256;
    localparam int BlockWidth = 128;
    localparam int CfgWidth   = 64;
    localparam int NumRounds  = 14;
    localparam int QueueDepth = 4;

    typedef enum logic [2:0] {
        REG_KEY0    = 3'd0,
        REG_KEY1    = 3'd1,
        REG_KEY2    = 3'd2,
        REG_KEY3    = 3'd3,
        REG_IV_HIGH = 3'd4,
        REG_IV_LOW  = 3'd5,
        REG_IV_LEN  = 3'd6,
        REG_NONE    = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_KEY,
        ENG_ROUND,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } eng_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits in bits 127-8i downto 120-8i.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

>>> src/aesctr_byte_if.sv
interface aesctr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

>>> src/aesctr_out_if.sv
interface aesctr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface

>>> src/aesctr_engine.sv
// Iterative AES-256 engine: one round and one round-key step per cycle.
// The key schedule runs alongside the rounds. The last eight schedule words
// are held as a 256-bit window that moves on by four words every round.
module aesctr_engine
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [aesctr_pkg::KeyWidth-1:0]   key,
    input  logic [aesctr_pkg::BlockWidth-1:0] block_in,
    output logic [aesctr_pkg::BlockWidth-1:0] block_out,
    output aesctr_pkg::eng_ctrl_t             ctrl
);

    aesctr_pkg::eng_state_t state_reg, state_next;
    logic [3:0]   round_reg, round_next;
    logic [127:0] state_blk_reg, state_blk_next;
    logic [255:0] win_reg, win_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] round_key;
    logic [127:0] rnd;
    logic [127:0] gen;
    logic [31:0]  w0, w1, w2, w3, tw;

    // The key for round r is always the newer half of the window.
    assign round_key = win_reg[127:0];

    // Next four schedule words from the window.
    always_comb
    begin
        if (round_reg[0])
        begin
            tw = aesctr_pkg::sub_word({win_reg[23:0], win_reg[31:24]}) ^ {rcon_reg, 24'd0};
        end
        else
        begin
            tw = aesctr_pkg::sub_word(win_reg[31:0]);
        end
        w0 = win_reg[255:224] ^ tw;
        w1 = win_reg[223:192] ^ w0;
        w2 = win_reg[191:160] ^ w1;
        w3 = win_reg[159:128] ^ w2;
        gen = {w0, w1, w2, w3};
    end

    always_comb
    begin
        rnd = aesctr_pkg::sub_shift(state_blk_reg);
        if (round_reg != 4'(aesctr_pkg::NumRounds))
        begin
            rnd = aesctr_pkg::mix_columns(rnd);
        end
        rnd = rnd ^ round_key;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aesctr_pkg::ENG_IDLE:
            begin
                if (start)
                begin
                    state_next = aesctr_pkg::ENG_ROUND;
                end
            end
            aesctr_pkg::ENG_ROUND:
            begin
                if (round_reg == 4'(aesctr_pkg::NumRounds))
                begin
                    state_next = aesctr_pkg::ENG_DONE;
                end
            end
            aesctr_pkg::ENG_DONE: state_next = aesctr_pkg::ENG_IDLE;
            default: state_next = aesctr_pkg::ENG_IDLE;
        endcase
    end

    always_comb
    begin
        round_next     = round_reg;
        state_blk_next = state_blk_reg;
        win_next       = win_reg;
        rcon_next      = rcon_reg;
        ctrl.start     = 1'b0;
        ctrl.busy      = 1'b0;
        ctrl.done      = 1'b0;
        case (state_reg)
            aesctr_pkg::ENG_IDLE:
            begin
                if (start)
                begin
                    ctrl.start     = 1'b1;
                    state_blk_next = block_in ^ key[255:128];
                    win_next       = key;
                    rcon_next      = 8'h01;
                    round_next     = 4'd1;
                end
            end
            aesctr_pkg::ENG_ROUND:
            begin
                ctrl.busy      = 1'b1;
                state_blk_next = rnd;
                round_next     = round_reg + 4'd1;
                // After an odd round the round constant moves on as well.
                if (round_reg[0])
                begin
                    win_next  = {win_reg[127:0], gen};
                    rcon_next = aesctr_pkg::xtime(rcon_reg);
                end
                else
                begin
                    win_next = {win_reg[127:0], gen};
                end
            end
            aesctr_pkg::ENG_DONE: ctrl.done = 1'b1;
            default: ctrl.busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aesctr_pkg::ENG_IDLE;
            round_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_blk_reg <= state_blk_next;
        win_reg       <= win_next;
        rcon_reg      <= rcon_next;
    end

    assign block_out = state_blk_reg;

endmodule

>>> src/aesctr_front.sv
// Accepts bytes into a short queue.
module aesctr_front
#(
    parameter int Depth = aesctr_pkg::QueueDepth
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           flush,
    aesctr_byte_if.sink    in_ch,
    output logic           q_valid,
    output logic [7:0]     q_byte,
    input  logic           q_pop
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    logic [7:0]  mem_reg [Depth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0] cnt_reg;
    logic        push;

    assign in_ch.ready = (cnt_reg != (AW+1)'(Depth));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_byte      = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (flush)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= (rd_reg == AW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_ch.data_byte;
        end
    end

endmodule

>>> src/aes256_ctr_keystream_xor.sv
// AES-256 counter-mode byte stream. Each accepted word on in_ch is XORed with
// the next keystream byte and returned on out_ch, most significant keystream
// byte first. A keystream block is produced by an iterative AES-256 engine
// that does one round per cycle with the key schedule running beside it. The
// engine is started on the next counter in the cycle after a block is taken
// into use. A small queue at the input lets the sender keep going while the
// back end waits for a block, and the output register decouples a stalled
// receiver. Any configuration write to indexes 0 to 6 reloads the counter
// and discards cached keystream; writes must only be made while the block is
// idle.
module aes256_ctr_keystream_xor
#(
    parameter int QueueDepth = aesctr_pkg::QueueDepth
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    aesctr_byte_if.sink                     in_ch,
    aesctr_out_if.source                    out_ch,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [aesctr_pkg::CfgWidth-1:0] cfg_data
);

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    logic [4:0]   ivlen_reg;
    logic [127:0] ctr_reg, ctr_next;   // counter of the next block to compute
    logic [127:0] ks_reg;              // keystream block in use
    logic [4:0]   left_reg;            // bytes still unused in ks_reg
    logic         pre_reg;             // engine result for ctr_reg is held
    logic         run_reg;             // engine is computing for ctr_reg
    logic [127:0] pre_blk_reg;
    logic         reload;
    logic         reload_d_reg;        // counter is loaded from the IV this cycle
    logic         q_valid, q_pop;
    logic [7:0]   q_byte;
    logic         ovalid_reg;
    logic [7:0]   obyte_reg;
    logic         out_free;
    logic         eng_start;
    logic [127:0] eng_out;
    logic [127:0] iv_full, iv_load;
    logic [4:0]   n_eff;
    logic         take;
    aesctr_pkg::eng_ctrl_t eng_ctrl;

    assign reload = cfg_we && (cfg_index != aesctr_pkg::REG_NONE);

    aesctr_front #(.Depth(QueueDepth)) u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .flush   (1'b0),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_byte  (q_byte),
        .q_pop   (q_pop)
    );

    // Engine starts when idle, no result is waiting for ctr_reg and the
    // counter and key are settled after a write.
    assign eng_start = !run_reg && !pre_reg && !reload && !reload_d_reg;

    aesctr_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .key       ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .block_in  (ctr_reg),
        .block_out (eng_out),
        .ctrl      (eng_ctrl)
    );

    assign out_free = !ovalid_reg || out_ch.ready;
    // A new keystream block is taken when the cache is empty, one is held and a byte can move out.
    assign take  = (left_reg == 5'd0) && pre_reg && q_valid && out_free;
    assign q_pop = q_valid && out_free && ((left_reg != 5'd0) || pre_reg) && !reload;

    // Counter load value from the IV registers and length.
    always_comb
    begin
        iv_full = {ivh_reg, ivl_reg};
        n_eff   = (ivlen_reg > 5'd16) ? 5'd16 : ivlen_reg;
        for (int i = 0; i < 16; i++)
        begin
            iv_load[127 - 8 * i -: 8] = (5'(i) < n_eff) ? iv_full[127 - 8 * i -: 8] : 8'h00;
        end
    end

    always_comb
    begin
        ctr_next = ctr_reg + 128'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            ivh_reg    <= '0;
            ivl_reg    <= '0;
            ivlen_reg  <= 5'd16;
            ctr_reg    <= '0;
            left_reg   <= '0;
            pre_reg    <= 1'b0;
            run_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (reload)
            begin
                case (cfg_index)
                    aesctr_pkg::REG_KEY0:    key0_reg  <= cfg_data;
                    aesctr_pkg::REG_KEY1:    key1_reg  <= cfg_data;
                    aesctr_pkg::REG_KEY2:    key2_reg  <= cfg_data;
                    aesctr_pkg::REG_KEY3:    key3_reg  <= cfg_data;
                    aesctr_pkg::REG_IV_HIGH: ivh_reg   <= cfg_data;
                    aesctr_pkg::REG_IV_LOW:  ivl_reg   <= cfg_data;
                    aesctr_pkg::REG_IV_LEN:  ivlen_reg <= cfg_data[4:0];
                    default: ivlen_reg <= ivlen_reg;
                endcase
                left_reg <= '0;
                pre_reg  <= 1'b0;
                run_reg  <= 1'b0;
            end
            else if (reload_d_reg)
            begin
                // The registers now hold the written value, so the counter
                // is loaded from them; no byte moves and the engine is not started here.
                ctr_reg <= iv_load;
            end
            else
            begin
                if (eng_ctrl.start)
                begin
                    run_reg <= 1'b1;
                end
                if (eng_ctrl.done && run_reg)
                begin
                    run_reg <= 1'b0;
                    pre_reg <= 1'b1;
                end
                if (q_pop)
                begin
                    if (take)
                    begin
                        pre_reg  <= 1'b0;
                        ctr_reg  <= ctr_next;
                        left_reg <= 5'd15;
                    end
                    else
                    begin
                        left_reg <= left_reg - 5'd1;
                    end
                end
            end
        end
    end

    // Counter reload needs the freshly written registers, so it follows in the
    // next cycle; the engine is held off meanwhile by the reload flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_d_reg <= 1'b1;
        end
        else
        begin
            reload_d_reg <= reload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_ctrl.done && run_reg)
        begin
            pre_blk_reg <= eng_out;
        end
        if (q_pop)
        begin
            if (take)
            begin
                ks_reg    <= {pre_blk_reg[119:0], 8'h00};
                obyte_reg <= q_byte ^ pre_blk_reg[127:120];
            end
            else
            begin
                ks_reg    <= {ks_reg[119:0], 8'h00};
                obyte_reg <= q_byte ^ ks_reg[127:120];
            end
        end
    end

    assign out_ch.valid    = ovalid_reg;
    assign out_ch.out_byte = obyte_reg;

endmodule

>>> src/aesctr_checker.sv
module aesctr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output word dropped under stall");

    a_no_out_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid || rst_n)
        else $error("output valid after reset");

    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("input ready unknown");

endmodule

bind aes256_ctr_keystream_xor aesctr_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte)
);

>>> tb/sv/aes256_ctr_keystream_checker.sv
`timescale 1ns / 1ps

module aes256_ctr_keystream_checker
    import aesctr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    aesctr_byte_if              in_ch,
    aesctr_out_if               out_ch,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [CfgWidth-1:0] cfg_data,
    output int                  failures,
    output int                  bytes_pending,
    output int                  bytes_checked
);

    logic [7:0]   sbox_rom [0:255];
    logic [63:0]  key_reg [4];
    logic [63:0]  iv_hi;
    logic [63:0]  iv_lo;
    logic [4:0]   iv_len;
    logic [127:0] counter_val;
    logic [127:0] keystream;
    int           ks_left;
    logic [127:0] round_key [15];
    logic [7:0]   expected_bytes [$];

    initial begin
        sbox_rom = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    end

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox_rom[w[31:24]], sbox_rom[w[23:16]], sbox_rom[w[15:8]], sbox_rom[w[7:0]]};
    endfunction

    // Byte i of a block is held in bits 127-8i downto 120-8i.
    function automatic logic [127:0] substitute_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
                t[127 - 8 * (row + 4 * col) -: 8] =
                    sbox_rom[s[127 - 8 * (row + 4 * ((col + row) % 4)) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] mix_block(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   b0, b1, b2, b3, sum;
        for (int col = 0; col < 4; col++)
        begin
            b0 = s[127 - 32 * col -: 8];
            b1 = s[119 - 32 * col -: 8];
            b2 = s[111 - 32 * col -: 8];
            b3 = s[103 - 32 * col -: 8];
            sum = b0 ^ b1 ^ b2 ^ b3;
            t[127 - 32 * col -: 8] = b0 ^ sum ^ gf_double(b0 ^ b1);
            t[119 - 32 * col -: 8] = b1 ^ sum ^ gf_double(b1 ^ b2);
            t[111 - 32 * col -: 8] = b2 ^ sum ^ gf_double(b2 ^ b3);
            t[103 - 32 * col -: 8] = b3 ^ sum ^ gf_double(b3 ^ b0);
        end
        return t;
    endfunction

    function automatic logic [127:0] encrypt_counter(input logic [127:0] blk);
        logic [127:0] s;
        s = blk ^ round_key[0];
        for (int r = 1; r < NumRounds; r++)
            s = mix_block(substitute_rows(s)) ^ round_key[r];
        return substitute_rows(s) ^ round_key[NumRounds];
    endfunction

    // Expands the key and reloads the counter; the keystream cache is emptied.
    function automatic void reload_context();
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [255:0] k;
        logic [127:0] iv;
        int           n;
        k = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
        for (int i = 0; i < 8; i++)
            w[i] = k[255 - 32 * i -: 32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i - 1];
            if (i % 8 == 0)
                t = sbox_word({t[23:0], t[31:24]}) ^ {8'h01 << (i / 8 - 1), 24'h0};
            else if (i % 8 == 4)
                t = sbox_word(t);
            w[i] = w[i - 8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        n  = (iv_len > 16) ? 16 : int'(iv_len);
        iv = {iv_hi, iv_lo};
        for (int i = 0; i < 16; i++)
            counter_val[127 - 8 * i -: 8] = (i < n) ? iv[127 - 8 * i -: 8] : 8'h00;
        ks_left = 0;
    endfunction

    function automatic logic [7:0] next_cipher_byte(input logic [7:0] b);
        logic [7:0] r;
        if (ks_left == 0)
        begin
            keystream = encrypt_counter(counter_val);
            ks_left   = 16;
        end
        r = b ^ keystream[127 - 8 * (16 - ks_left) -: 8];
        ks_left--;
        if (ks_left == 0)
            counter_val = counter_val + 128'd1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] = '0;
            iv_hi     = '0;
            iv_lo     = '0;
            iv_len    = 5'd16;
            keystream = '0;
            reload_context();
            expected_bytes.delete();
            failures      = 0;
            bytes_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_KEY0:    key_reg[0] = cfg_data;
                    REG_KEY1:    key_reg[1] = cfg_data;
                    REG_KEY2:    key_reg[2] = cfg_data;
                    REG_KEY3:    key_reg[3] = cfg_data;
                    REG_IV_HIGH: iv_hi = cfg_data;
                    REG_IV_LOW:  iv_lo = cfg_data;
                    REG_IV_LEN:  iv_len = cfg_data[4:0];
                    default: ;
                endcase
                if (reg_index_t'(cfg_index) != REG_NONE)
                    reload_context();
            end
            if (in_ch.valid && in_ch.ready)
                expected_bytes.push_back(next_cipher_byte(in_ch.data_byte));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected out_byte %02h, nothing outstanding",
                             $time, out_ch.out_byte);
                    failures++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (out_ch.out_byte !== want)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, out_ch.out_byte);
                        failures++;
                    end
                end
            end
        end
        bytes_pending = expected_bytes.size();
    end

endmodule

>>> tb/sv/aes256_ctr_keystream_xor_tb.sv
`timescale 1ns / 1ps

module aes256_ctr_keystream_xor_tb;

    // Cycles with no word moving on either channel before the run is abandoned.
    // The longest honest quiet spell is the deliberate receiver hold or a fresh
    // keystream block after a reload.
    localparam int WatchdogLimit = 3000;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 40;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    aesctr_pkg::reg_index_t          cfg_index;
    logic [aesctr_pkg::CfgWidth-1:0] cfg_data;
    int                              failures;
    int                              bytes_pending;
    int                              bytes_checked;
    int                              bytes_sent;
    int                              settings_used;
    int                              quiet_cycles;
    bit                              idling_on;
    bit                              hold_request;

    aesctr_byte_if in_ch ();
    aesctr_out_if  out_ch ();

    aes256_ctr_keystream_xor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aes256_ctr_keystream_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .bytes_pending (bytes_pending),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The watchdog restarts whenever a word is accepted on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("%0t: watchdog expired with %0d bytes outstanding",
                     $time, bytes_pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver. It normally takes words in runs, stalls for short random
    // bursts while idling is on, and once on request holds off for a long
    // stretch so that the output register and input queue fill and the
    // block has to push back on the sender.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // One register write; the write enable drops again on the following edge.
    task automatic write_reg(input aesctr_pkg::reg_index_t idx,
                             input logic [aesctr_pkg::CfgWidth-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_context(input logic [255:0] key, input logic [127:0] iv,
                                input logic [4:0] iv_len);
        write_reg(aesctr_pkg::REG_KEY0, key[255:192]);
        write_reg(aesctr_pkg::REG_KEY1, key[191:128]);
        write_reg(aesctr_pkg::REG_KEY2, key[127:64]);
        write_reg(aesctr_pkg::REG_KEY3, key[63:0]);
        write_reg(aesctr_pkg::REG_IV_HIGH, iv[127:64]);
        write_reg(aesctr_pkg::REG_IV_LOW, iv[63:0]);
        write_reg(aesctr_pkg::REG_IV_LEN, {59'd0, iv_len});
        settings_used++;
    endtask

    // Offers one word and waits for it to be taken. A word that follows
    // straight on keeps valid high, so valid is never dropped and raised in
    // the same step.
    task automatic send_word(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(8'($urandom));
    endtask

    // Configuration must only change once the block is idle: every byte has
    // come back and the engine has had time to finish any block it started
    // ahead of need. Valid drops at once, as the last word has been taken.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    initial
    begin
        logic [255:0] key;
        logic [127:0] iv;
        logic [4:0]   iv_len;
        int           len;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = aesctr_pkg::REG_KEY0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        idling_on       = 1'b1;
        hold_request    = 1'b0;
        quiet_cycles    = 0;
        bytes_sent      = 0;
        settings_used   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. First the reset context (all-zero key and counter):
        // extreme byte values and a crossing into the second keystream block.
        send_word(8'h00);
        send_word(8'hff);
        send_word(8'h55);
        send_word(8'haa);
        send_word(8'h01);
        send_word(8'h80);
        send_random(12);
        wait_idle();

        // Counter of all ones, so the block boundary wraps it to zero. An
        // iv_length past 16 must behave as 16.
        load_context({256{1'b1}}, {128{1'b1}}, 5'd31);
        send_random(20);
        wait_idle();

        // No IV bytes used at all; then a write to the unused index, which
        // must leave the running stream untouched.
        load_context({8{32'ha5c3_0f96}}, {128{1'b1}}, 5'd0);
        send_random(5);
        wait_idle();
        write_reg(aesctr_pkg::REG_NONE, {aesctr_pkg::CfgWidth{1'b1}});
        send_random(15);
        wait_idle();

        // Random part: about 600 bytes over a series of fresh contexts, with
        // short phases for frequent reloads and one long receiver hold.
        for (int phase = 0; phase < 16; phase++)
        begin
            key = {$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
            iv  = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 3))
                0: iv_len = 5'd16;
                1: iv_len = 5'($urandom_range(0, 31));
                2: iv_len = 5'($urandom_range(0, 16));
                default:
                begin
                    // Counter close to wrapping within this phase.
                    iv_len = 5'd16;
                    iv[63:0] = 64'hffff_ffff_ffff_fffe - 64'($urandom_range(0, 2));
                    iv[127:64] = {64{1'b1}};
                end
            endcase
            // Single key words and IV parts are sometimes rewritten alone.
            load_context(key, iv, iv_len);
            if ($urandom_range(0, 2) == 0)
                write_reg(aesctr_pkg::reg_index_t'($urandom_range(0, 6)),
                          {$urandom, $urandom});
            if (phase == 5)
                hold_request = 1'b1;
            // The last phases run with neither side idling.
            if (phase >= 13)
                idling_on = 1'b0;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : $urandom_range(30, 60);
            send_random(len);
            wait_idle();
        end

        $display("Sent %0d bytes over %0d key and counter settings, %0d bytes checked.",
                 bytes_sent, settings_used, bytes_checked);
        $display("Covered counter wrap, zero and over-long IV lengths and a long output stall.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
